>>> src/mpm_pkg.sv
// ----------------------------------------------------------------------------
// mpm_pkg
// Shared types and constants of the min-plus matrix product block.
// ----------------------------------------------------------------------------
`default_nettype none

package mpm_pkg;

	localparam int unsigned MAX_N   = 64;
	localparam int unsigned IDX_W   = $clog2(MAX_N);
	localparam int unsigned N_W     = IDX_W + 1;
	localparam int unsigned ADDR_W  = 2 * IDX_W;
	localparam int unsigned DEPTH   = MAX_N * MAX_N;
	localparam int unsigned DATA_W  = 32;
	localparam int unsigned PDATA_W = 32;
	localparam int unsigned PADDR_W = 3;
	localparam int unsigned SIZE_W  = 7;

	localparam logic [DATA_W-1:0] DIST_INF = '1;
	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(64);

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [PADDR_W-3:0] REG_MATRIX_SIZE = '0;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_DONE
	} mpm_state_t;

	typedef struct packed {
		logic             write;
		logic             capture;
		logic             issue;
		logic [IDX_W-1:0] k;
		logic             out_load;
	} mpm_cmd_t;

	typedef struct packed {
		logic pipe_busy;
		logic out_full;
		logic out_take;
	} mpm_status_t;

endpackage

`default_nettype wire

>>> src/mpm_if.sv
// ----------------------------------------------------------------------------
// mpm_if
// Valid/ready channels: request beats in, result beats out.
// ----------------------------------------------------------------------------
`default_nettype none

interface mpm_in_if;
	logic                        valid;
	logic                        ready;
	logic                        op;
	logic [mpm_pkg::IDX_W-1:0]   row;
	logic [mpm_pkg::IDX_W-1:0]   col;
	logic [mpm_pkg::DATA_W-1:0]  value;

	modport source (output valid, op, row, col, value, input ready);
	modport sink   (input valid, op, row, col, value, output ready);
endinterface

interface mpm_out_if;
	logic                        valid;
	logic                        ready;
	logic [mpm_pkg::DATA_W-1:0]  shortest;
	logic [mpm_pkg::IDX_W-1:0]   out_row;
	logic [mpm_pkg::IDX_W-1:0]   out_col;

	modport source (output valid, shortest, out_row, out_col, input ready);
	modport sink   (input valid, shortest, out_row, out_col, output ready);
endinterface

`default_nettype wire

>>> src/mpm_ram.sv
// ----------------------------------------------------------------------------
// mpm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mpm_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 4096,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

>>> src/mpm_regs.sv
// ----------------------------------------------------------------------------
// mpm_regs
// APB register file: matrix size.
// ----------------------------------------------------------------------------
`default_nettype none

module mpm_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [mpm_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [mpm_pkg::PDATA_W-1:0]   pwdata,
	output logic      [mpm_pkg::PDATA_W-1:0]   prdata,
	output logic                               pready,
	output logic      [mpm_pkg::SIZE_W-1:0]    matrix_size
);

	logic [mpm_pkg::SIZE_W-1:0] size_q;
	logic                       hit;

	assign hit    = (paddr[mpm_pkg::PADDR_W-1:2] == mpm_pkg::REG_MATRIX_SIZE);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= mpm_pkg::SIZE_RESET;
		end else if (psel && penable && pwrite && hit) begin
			size_q <= pwdata[mpm_pkg::SIZE_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (hit) begin
			prdata = mpm_pkg::PDATA_W'(size_q);
		end
	end

	assign matrix_size = size_q;

endmodule

`default_nettype wire

>>> src/mpm_ctrl.sv
// ----------------------------------------------------------------------------
// mpm_ctrl
// Controller: accepts beats, sequences k over the matrix, hands off result.
// ----------------------------------------------------------------------------
`default_nettype none

module mpm_ctrl (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	input  wire logic                        in_op,
	output logic                             in_ready,
	input  wire logic [mpm_pkg::SIZE_W-1:0]  matrix_size,
	input  wire mpm_pkg::mpm_status_t        status,
	output mpm_pkg::mpm_cmd_t                cmd
);

	mpm_pkg::mpm_state_t          state_q, state_d;
	logic [mpm_pkg::IDX_W-1:0]    k_q;
	logic [mpm_pkg::N_W-1:0]      n_q;
	logic [mpm_pkg::N_W-1:0]      n_eff;
	logic                         accept;
	logic                         last_k;

	assign n_eff  = (matrix_size > mpm_pkg::SIZE_W'(mpm_pkg::MAX_N))
		? mpm_pkg::N_W'(mpm_pkg::MAX_N) : mpm_pkg::N_W'(matrix_size);
	assign accept = in_valid && in_ready;
	assign last_k = ({1'b0, k_q} == (n_q - mpm_pkg::N_W'(1)));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mpm_pkg::ST_IDLE: begin
				if (accept && in_op == mpm_pkg::OP_QUERY) begin
					state_d = (n_eff == '0) ? mpm_pkg::ST_DRAIN : mpm_pkg::ST_RUN;
				end
			end
			mpm_pkg::ST_RUN: begin
				if (last_k) begin
					state_d = mpm_pkg::ST_DRAIN;
				end
			end
			mpm_pkg::ST_DRAIN: begin
				if (!status.pipe_busy) begin
					state_d = mpm_pkg::ST_DONE;
				end
			end
			mpm_pkg::ST_DONE: begin
				if (!status.out_full || status.out_take) begin
					state_d = mpm_pkg::ST_IDLE;
				end
			end
			default: state_d = mpm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready     = 1'b0;
		cmd          = '0;
		cmd.k        = k_q;
		unique case (state_q)
			mpm_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.write   = in_valid && in_op == mpm_pkg::OP_LOAD;
				cmd.capture = in_valid && in_op == mpm_pkg::OP_QUERY;
			end
			mpm_pkg::ST_RUN: begin
				cmd.issue = 1'b1;
			end
			mpm_pkg::ST_DRAIN: begin
			end
			mpm_pkg::ST_DONE: begin
				cmd.out_load = !status.out_full || status.out_take;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mpm_pkg::ST_IDLE;
			k_q     <= '0;
			n_q     <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.capture) begin
				k_q <= '0;
				n_q <= n_eff;
			end else if (cmd.issue) begin
				k_q <= k_q + mpm_pkg::IDX_W'(1);
			end
		end
	end

	// a query owns the datapath until its result is handed off
	a_capture_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> !in_ready)
		else $error("input accepted while a query is in flight");

	a_k_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == mpm_pkg::ST_RUN |-> ({1'b0, k_q} < n_q))
		else $error("k beyond matrix size");

endmodule

`default_nettype wire

>>> src/mpm_dp.sv
// ----------------------------------------------------------------------------
// mpm_dp
// Datapath: two copies of the distance store, saturating add, running minimum,
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mpm_dp (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire mpm_pkg::mpm_cmd_t            cmd,
	output mpm_pkg::mpm_status_t              status,
	input  wire logic [mpm_pkg::IDX_W-1:0]    in_row,
	input  wire logic [mpm_pkg::IDX_W-1:0]    in_col,
	input  wire logic [mpm_pkg::DATA_W-1:0]   in_value,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic      [mpm_pkg::DATA_W-1:0]   shortest,
	output logic      [mpm_pkg::IDX_W-1:0]    out_row,
	output logic      [mpm_pkg::IDX_W-1:0]    out_col
);

	logic [mpm_pkg::IDX_W-1:0]  row_q, col_q;
	logic [mpm_pkg::DATA_W-1:0] a_s1, b_s1;
	logic [mpm_pkg::DATA_W-1:0] sum_s2;
	logic [mpm_pkg::DATA_W-1:0] best_q;
	logic [mpm_pkg::DATA_W:0]   wide_sum;
	logic [mpm_pkg::DATA_W-1:0] sat_sum;
	logic                       vld_s1, vld_s2;
	logic                       out_valid_q;
	logic [mpm_pkg::DATA_W-1:0] shortest_q;
	logic [mpm_pkg::IDX_W-1:0]  out_row_q, out_col_q;
	logic [mpm_pkg::ADDR_W-1:0] wr_addr;

	assign wr_addr = {in_row, in_col};

	// store A read by row (d[i][k]), store B by column (d[k][j])
	mpm_ram #(.WIDTH(mpm_pkg::DATA_W), .DEPTH(mpm_pkg::DEPTH)) u_ram_a (
		.clk     (clk),
		.wr_en   (cmd.write),
		.wr_addr (wr_addr),
		.wr_data (in_value),
		.rd_en   (cmd.issue),
		.rd_addr ({row_q, cmd.k}),
		.rd_data (a_s1)
	);

	mpm_ram #(.WIDTH(mpm_pkg::DATA_W), .DEPTH(mpm_pkg::DEPTH)) u_ram_b (
		.clk     (clk),
		.wr_en   (cmd.write),
		.wr_addr (wr_addr),
		.wr_data (in_value),
		.rd_en   (cmd.issue),
		.rd_addr ({cmd.k, col_q}),
		.rd_data (b_s1)
	);

	// infinity plus anything already reaches the all-ones bound
	assign wide_sum = {1'b0, a_s1} + {1'b0, b_s1};
	assign sat_sum  = (wide_sum >= {1'b0, mpm_pkg::DIST_INF})
		? mpm_pkg::DIST_INF : wide_sum[mpm_pkg::DATA_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			vld_s1 <= cmd.issue;
			vld_s2 <= vld_s1;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			row_q  <= in_row;
			col_q  <= in_col;
			best_q <= mpm_pkg::DIST_INF;
		end else if (vld_s2 && sum_s2 < best_q) begin
			best_q <= sum_s2;
		end
		if (vld_s1) begin
			sum_s2 <= sat_sum;
		end
		if (cmd.out_load) begin
			shortest_q <= best_q;
			out_row_q  <= row_q;
			out_col_q  <= col_q;
		end
	end

	assign status.pipe_busy = vld_s1 || vld_s2;
	assign status.out_full  = out_valid_q;
	assign status.out_take  = out_valid_q && out_ready;

	assign out_valid = out_valid_q;
	assign shortest  = shortest_q;
	assign out_row   = out_row_q;
	assign out_col   = out_col_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result register overwritten before hand-off");

	a_pipe_empty_on_capture: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |-> (!vld_s1 && !vld_s2 && !cmd.issue))
		else $error("new query started with sums still in flight");

endmodule

`default_nettype wire

>>> src/min_plus_matrix_product.sv
// ----------------------------------------------------------------------------
// min_plus_matrix_product
// One-hop shortcut (min-plus product) over an n-by-n Q16.16 distance matrix.
// ----------------------------------------------------------------------------
// A load beat (op 0) writes one distance into the store. A query beat (op 1)
// returns min over k < n of d[row][k] + d[k][col], with saturation to
// all-ones (infinity); it occupies the block until its result is loaded into
// the output register, as one pair of elements per cycle is read from two
// copies of the store and fed through a single add-and-min path. The result
// sits in the output register, so the next beat is accepted while it waits.
// Every entry a query reads must have been loaded first; the store is not
// cleared at reset. Matrix size sits at APB address 0 and should only be
// changed while the block is idle.
`default_nettype none

module min_plus_matrix_product (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	mpm_in_if.sink                            in_ch,
	mpm_out_if.source                         out_ch,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [mpm_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [mpm_pkg::PDATA_W-1:0]  pwdata,
	output logic      [mpm_pkg::PDATA_W-1:0]  prdata,
	output logic                              pready
);

	logic [mpm_pkg::SIZE_W-1:0] matrix_size;
	mpm_pkg::mpm_cmd_t          cmd;
	mpm_pkg::mpm_status_t       status;

	mpm_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.matrix_size (matrix_size)
	);

	mpm_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_ch.valid),
		.in_op       (in_ch.op),
		.in_ready    (in_ch.ready),
		.matrix_size (matrix_size),
		.status      (status),
		.cmd         (cmd)
	);

	mpm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_row    (in_ch.row),
		.in_col    (in_ch.col),
		.in_value  (in_ch.value),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.shortest  (out_ch.shortest),
		.out_row   (out_ch.out_row),
		.out_col   (out_ch.out_col)
	);

endmodule

`default_nettype wire
